@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/crr_pkg.sv @@
`default_nettype none
package crr_pkg;
    localparam int unsigned HitWidth = 7;

    localparam logic FuncWrite     = 1'b0;
    localparam logic FuncTranslate = 1'b1;

    typedef struct packed {
        logic        func;
        logic [2:0]  stage_sel;
        logic [4:0]  entry_index;
        logic        entry_valid;
        logic [31:0] source_start;
        logic [31:0] dest_start;
        logic [31:0] span_length;
        logic [31:0] value_in;
    } t_in_req;

    typedef struct packed {
        logic [31:0]         value_out;
        logic [HitWidth-1:0] stage_hits;
    } t_out_req;

    // A window write as seen by every remap stage.
    typedef struct packed {
        logic        en;
        logic [2:0]  stage_sel;
        logic [4:0]  entry_index;
        logic        entry_valid;
        logic [31:0] source_start;
        logic [31:0] dest_start;
        logic [31:0] span_length;
    } t_win_wr;
endpackage
`default_nettype wire

@@ sv/cascaded_range_remap_top.sv @@
`default_nettype none
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_stall    i_req  (t_in_req)
// result    out        o_valid / i_stall    o_res  (t_out_req)
//
// A translate request can be taken in every cycle in which the pipeline is not held;
// the pipeline is held whole while a result waits under i_stall.
// A window write waits until no translate request is in the stages, is applied as it
// is taken and gives no result.
// After reset every window is disabled; no clearing pass is needed.
module cascaded_range_remap_top
    import crr_pkg::*;
#(
    parameter int unsigned STAGES  = 7,
    parameter int unsigned ENTRIES = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output      logic     o_stall,
    input  wire t_in_req  i_req,
    output      logic     o_valid,
    input  wire logic     i_stall,
    output      t_out_req o_res
);
    logic                w_adv;
    logic                w_wr_block;
    logic [STAGES-1:0]   w_busy;
    t_win_wr             w_wr;
    logic                w_vld [STAGES+1];
    logic [31:0]         w_val [STAGES+1];
    logic [HitWidth-1:0] w_hit [STAGES+1];
    logic                r_ovld;
    t_out_req            r_ores;

    // The output register may be refilled whenever it is empty or being taken.
    assign w_adv      = !r_ovld || !i_stall;
    assign w_wr_block = i_valid && (i_req.func == FuncWrite) && (|w_busy);
    assign o_stall    = !w_adv || w_wr_block;

    assign w_wr.en           = i_valid && w_adv && !w_wr_block && (i_req.func == FuncWrite);
    assign w_wr.stage_sel    = i_req.stage_sel;
    assign w_wr.entry_index  = i_req.entry_index;
    assign w_wr.entry_valid  = i_req.entry_valid;
    assign w_wr.source_start = i_req.source_start;
    assign w_wr.dest_start   = i_req.dest_start;
    assign w_wr.span_length  = i_req.span_length;

    assign w_vld[0] = i_valid && (i_req.func == FuncTranslate);
    assign w_val[0] = i_req.value_in;
    assign w_hit[0] = '0;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        crr_stage #(
            .ENTRIES  (ENTRIES),
            .STAGE_NUM(s)
        ) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (w_adv),
            .i_wr   (w_wr),
            .i_vld  (w_vld[s]),
            .i_value(w_val[s]),
            .i_hits (w_hit[s]),
            .o_vld  (w_vld[s+1]),
            .o_value(w_val[s+1]),
            .o_hits (w_hit[s+1]),
            .o_busy (w_busy[s])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_adv) begin
            r_ovld <= w_vld[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ores.value_out  <= w_val[STAGES];
            r_ores.stage_hits <= w_hit[STAGES];
        end
    end

    assign o_valid = r_ovld;
    assign o_res   = r_ores;
endmodule
`default_nettype wire

@@ sv/crr_stage.sv @@
`default_nettype none
// One remap table, three register steps: compare, select, add.
module crr_stage
    import crr_pkg::*;
#(
    parameter int unsigned ENTRIES   = 32,
    parameter int unsigned STAGE_NUM = 0
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_adv,
    input  wire t_win_wr             i_wr,
    input  wire logic                i_vld,
    input  wire logic [31:0]         i_value,
    input  wire logic [HitWidth-1:0] i_hits,
    output      logic                o_vld,
    output      logic [31:0]         o_value,
    output      logic [HitWidth-1:0] o_hits,
    output      logic                o_busy
);
    localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [ENTRIES-1:0] r_wvalid;
    logic [31:0]        r_wsrc [ENTRIES];
    logic [31:0]        r_wdst [ENTRIES];
    logic [32:0]        r_wend [ENTRIES];

    logic [ENTRIES-1:0]  r_match;
    logic [31:0]         r_v1;
    logic [HitWidth-1:0] r_h1;
    logic                r_vld1;

    logic [31:0]         r_v2;
    logic [31:0]         r_delta2;
    logic                r_hit2;
    logic [HitWidth-1:0] r_h2;
    logic                r_vld2;

    logic [31:0]         r_v3;
    logic [HitWidth-1:0] r_h3;
    logic                r_vld3;

    logic [ENTRIES-1:0]  n_match;
    logic [IdxW-1:0]     n_sel;
    logic                n_any;
    logic [HitWidth-1:0] n_h2;
    logic                w_sel_stage;

    assign w_sel_stage = i_wr.en && (32'(i_wr.stage_sel) == 32'(STAGE_NUM))
                         && (32'(i_wr.entry_index) < 32'(ENTRIES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
        end else if (w_sel_stage) begin
            r_wvalid[IdxW'(i_wr.entry_index)] <= i_wr.entry_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel_stage) begin
            r_wsrc[IdxW'(i_wr.entry_index)] <= i_wr.source_start;
            r_wdst[IdxW'(i_wr.entry_index)] <= i_wr.dest_start;
            r_wend[IdxW'(i_wr.entry_index)] <= {1'b0, i_wr.source_start}
                                               + {1'b0, i_wr.span_length};
        end
    end

    always_comb begin
        for (int e = 0; e < ENTRIES; e++) begin
            n_match[e] = r_wvalid[e] && (i_value >= r_wsrc[e])
                         && ({1'b0, i_value} < r_wend[e]);
        end
    end

    always_comb begin
        n_sel = '0;
        n_any = 1'b0;
        for (int e = ENTRIES - 1; e >= 0; e--) begin
            if (r_match[e]) begin
                n_sel = IdxW'(e);
                n_any = 1'b1;
            end
        end
    end

    always_comb begin
        n_h2 = r_h1;
        if (STAGE_NUM < HitWidth) begin
            n_h2[STAGE_NUM % HitWidth] = n_any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_adv) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_match  <= n_match;
            r_v1     <= i_value;
            r_h1     <= i_hits;
            r_v2     <= r_v1;
            r_delta2 <= r_wdst[n_sel] - r_wsrc[n_sel];
            r_hit2   <= n_any;
            r_h2     <= n_h2;
            r_v3 <= r_hit2 ? (r_v2 + r_delta2) : r_v2;
            r_h3 <= r_h2;
        end
    end

    assign o_vld   = r_vld3;
    assign o_value = r_v3;
    assign o_hits  = r_h3;
    assign o_busy  = r_vld1 || r_vld2 || r_vld3;
endmodule
`default_nettype wire

@@ sv/crr_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module crr_checker
    import crr_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_valid,
    input wire logic     o_stall,
    input wire t_in_req  i_req,
    input wire logic     o_valid,
    input wire logic     i_stall,
    input wire t_out_req o_res
);
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_res)), "stalled result changed")
    `ASSERT_CLK(a_stall_cause, i_clk, i_rst_n, o_stall |-> ((o_valid && i_stall) || (i_valid && i_req.func == FuncWrite)), "input stalled without a cause")
    `ASSERT_CLK(a_no_stall_free, i_clk, i_rst_n, (!o_valid && i_req.func == FuncTranslate) |-> !o_stall, "translate stalled while output empty")
    `ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "result after reset")
endmodule

bind cascaded_range_remap_top crr_checker u_crr_checker (.*);
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import crr_pkg::*;

    localparam int unsigned STAGES  = 7;
    localparam int unsigned ENTRIES = 32;
    localparam int unsigned RANDOM_REQS = 1850;
    localparam int unsigned LATENCY = 3 * STAGES + 1;

    typedef struct packed {
        t_in_req  req;
        logic     typed;
        t_out_req res;
    } t_row;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_stall;
    t_in_req  i_req = '0;
    logic     o_valid;
    logic     i_stall = 1'b0;
    t_out_req o_res;

    logic        win_on  [STAGES][ENTRIES];
    logic [31:0] win_src [STAGES][ENTRIES];
    logic [31:0] win_dst [STAGES][ENTRIES];
    logic [31:0] win_len [STAGES][ENTRIES];

    t_row     stim_q[$];
    t_out_req pending_results[$];
    int       next_req = 0;
    int       taken_reqs = 0;
    int       errors = 0;
    logic     hold_off = 1'b0;

    cascaded_range_remap_top #(.STAGES(STAGES), .ENTRIES(ENTRIES)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_req(i_req),
        .o_valid(o_valid), .i_stall(i_stall), .o_res(o_res)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_out_req remap_value(logic [31:0] v_in);
        t_out_req r;
        logic [31:0] v;
        logic found;
        v = v_in;
        r = '0;
        for (int s = 0; s < STAGES; s++) begin
            found = 1'b0;
            for (int e = 0; e < ENTRIES; e++) begin
                if (!found && win_on[s][e] && v >= win_src[s][e]
                    && {1'b0, v} < {1'b0, win_src[s][e]} + {1'b0, win_len[s][e]}) begin
                    found = 1'b1;
                    v = win_dst[s][e] + (v - win_src[s][e]);
                end
            end
            if (found && s < HitWidth) r.stage_hits[s] = 1'b1;
        end
        r.value_out = v;
        return r;
    endfunction

    function automatic t_row mk_row(logic f, int st, int slot, logic en, logic [31:0] src,
                                    logic [31:0] dst, logic [31:0] len, logic [31:0] v,
                                    logic typed, logic [31:0] ev, logic [6:0] eh);
        t_row row;
        row.req = '{f, st[2:0], slot[4:0], en, src, dst, len, v};
        row.typed = typed;
        row.res = '{ev, eh};
        return row;
    endfunction

    function automatic t_row rand_row();
        t_row row;
        row.req = $bits(t_in_req)'({$urandom, $urandom, $urandom, $urandom, $urandom});
        row.typed = 1'b0;
        row.res = '0;
        if ($urandom_range(0, 99) < 30) begin
            row.req.func = FuncWrite;
            row.req.entry_valid = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 9) < 8) begin
                row.req.source_start = $urandom_range(0, 1000);
                row.req.dest_start = $urandom_range(0, 1100);
                row.req.span_length = $urandom_range(0, 300);
            end
        end else begin
            row.req.func = FuncTranslate;
            if ($urandom_range(0, 9) < 7) row.req.value_in = $urandom_range(0, 1100);
        end
        return row;
    endfunction

    function automatic int idle_pct(int n, logic rx);
        if (n < 400) return 0;
        if (n < 800) return rx ? 0 : 88;
        if (n < 1200) return rx ? 88 : 0;
        if (n < 1600) return 26;
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_row row;
        if (i_rst_n && i_valid && !o_stall) begin
            if (i_req.func == FuncWrite) begin
                if (i_req.stage_sel < STAGES && i_req.entry_index < ENTRIES) begin
                    win_on[i_req.stage_sel][i_req.entry_index] <= i_req.entry_valid;
                    win_src[i_req.stage_sel][i_req.entry_index] <= i_req.source_start;
                    win_dst[i_req.stage_sel][i_req.entry_index] <= i_req.dest_start;
                    win_len[i_req.stage_sel][i_req.entry_index] <= i_req.span_length;
                end
            end else if (stim_q[taken_reqs].typed) begin
                pending_results.push_back(stim_q[taken_reqs].res);
            end else begin
                pending_results.push_back(remap_value(i_req.value_in));
            end
            taken_reqs <= taken_reqs + 1;
        end
        if (i_rst_n && (!i_valid || !o_stall)) begin
            if (next_req < stim_q.size() && $urandom_range(0, 99) >= idle_pct(next_req, 1'b0)) begin
                row = stim_q[next_req];
                i_req <= row.req;
                i_valid <= 1'b1;
                next_req <= next_req + 1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value_out=%h stage_hits=%b",
                         $time, o_res.value_out, o_res.stage_hits);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_res.value_out !== want.value_out) begin
                    $display("%0t: value_out expected %h actual %h",
                             $time, want.value_out, o_res.value_out);
                    errors++;
                end
                if (o_res.stage_hits !== want.stage_hits) begin
                    $display("%0t: stage_hits expected %b actual %b",
                             $time, want.stage_hits, o_res.stage_hits);
                    errors++;
                end
            end
        end
        i_stall <= i_rst_n && (hold_off || $urandom_range(0, 99) < idle_pct(next_req, 1'b1));
    end

    initial begin
        wait (next_req >= stim_q.size() - 150 && stim_q.size() > 0);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        for (int s = 0; s < STAGES; s++) begin
            for (int e = 0; e < ENTRIES; e++) begin
                win_on[s][e] = 1'b0;
                win_src[s][e] = '0;
                win_dst[s][e] = '0;
                win_len[s][e] = '0;
            end
        end
        // Directed requests: reset state, exclusive end, ignored stage, zero length,
        // window at the top, disabling, wrap of the destination sum and overlapping windows.
        stim_q.push_back(mk_row(FuncTranslate, 0, 0, 0, 0, 0, 0, 32'h0, 1, 32'h0, 7'h00));
        stim_q.push_back(mk_row(FuncTranslate, 7, 31, 1, '1, '1, '1, '1, 1, '1, 7'h00));
        stim_q.push_back(mk_row(FuncWrite, 0, 0, 1, 100, 200, 10, 0, 0, 0, 0));
        stim_q.push_back(mk_row(FuncTranslate, 0, 0, 0, 0, 0, 0, 100, 1, 200, 7'h01));
        stim_q.push_back(mk_row(FuncTranslate, 0, 0, 0, 0, 0, 0, 109, 1, 209, 7'h01));
        stim_q.push_back(mk_row(FuncTranslate, 0, 0, 0, 0, 0, 0, 110, 1, 110, 7'h00));
        stim_q.push_back(mk_row(FuncWrite, 7, 0, 1, 0, 5, '1, 0, 0, 0, 0));
        stim_q.push_back(mk_row(FuncTranslate, 0, 0, 0, 0, 0, 0, 5, 1, 5, 7'h00));
        stim_q.push_back(mk_row(FuncWrite, 1, 31, 1, 0, 5, 0, 0, 0, 0, 0));
        stim_q.push_back(mk_row(FuncTranslate, 0, 0, 0, 0, 0, 0, 0, 1, 0, 7'h00));
        stim_q.push_back(mk_row(FuncWrite, 6, 3, 1, 32'hFFFF_FFF0, 0, '1, 0, 0, 0, 0));
        stim_q.push_back(mk_row(FuncTranslate, 0, 0, 0, 0, 0, 0, '1, 1, 32'hF, 7'h40));
        stim_q.push_back(mk_row(FuncWrite, 0, 0, 0, 100, 200, 10, 0, 0, 0, 0));
        stim_q.push_back(mk_row(FuncTranslate, 0, 0, 0, 0, 0, 0, 100, 1, 100, 7'h00));
        stim_q.push_back(mk_row(FuncWrite, 2, 0, 1, 0, '1, 2, 0, 0, 0, 0));
        stim_q.push_back(mk_row(FuncTranslate, 0, 0, 0, 0, 0, 0, 1, 1, 0, 7'h04));
        stim_q.push_back(mk_row(FuncWrite, 3, 10, 1, 0, 50, 1000, 0, 0, 0, 0));
        stim_q.push_back(mk_row(FuncWrite, 3, 5, 1, 0, 70, 1000, 0, 0, 0, 0));
        stim_q.push_back(mk_row(FuncTranslate, 0, 0, 0, 0, 0, 0, 3, 0, 0, 0));
        stim_q.push_back(mk_row(FuncTranslate, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 0, 0, 0));
        for (int n = 0; n < RANDOM_REQS; n++) stim_q.push_back(rand_row());

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (taken_reqs == stim_q.size());
        wait (pending_results.size() == 0);
        repeat (4 * LATENCY) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
